### rtl/assert_macros.svh
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// implication checked on every clock, off while reset is low
`define MQSB_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: lbl");

// invariant checked on every clock, off while reset is low
`define MQSB_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed: lbl");

`endif

### rtl/mqsb_pkg.sv
package mqsb_pkg;

    // action codes
    localparam logic ACT_ENQ = 1'b0;
    localparam logic ACT_DEQ = 1'b1;

    // status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_FULL  = 2'd1;
    localparam logic [1:0] ST_EMPTY = 2'd2;

    // word returned by a refused dequeue
    localparam logic signed [31:0] EMPTY_WORD = -32'sd1;

    // input beat
    typedef struct packed {
        logic               action;
        logic [1:0]         queue_id;
        logic signed [31:0] data_in;
    } t_item;

    // result beat
    typedef struct packed {
        logic signed [31:0] data_out;
        logic [1:0]         status;
    } t_result;

    // controller to datapath commands
    typedef struct packed {
        logic launch;
        logic commit;
    } t_cmd;

endpackage

### rtl/mqsb_ctrl.sv
`include "assert_macros.svh"

module mqsb_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          start,
    output logic          busy,
    output mqsb_pkg::t_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE   = 2'b01,
        S_COMMIT = 2'b10
    } t_state;

    t_state r_state;
    t_state n_state;

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (start) n_state = S_COMMIT;
            end
            S_COMMIT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // commands and handshake
    assign busy         = (r_state == S_COMMIT);
    assign o_cmd.launch = start && (r_state == S_IDLE);
    assign o_cmd.commit = (r_state == S_COMMIT);

    `MQSB_ASSERT_IMPL(a_launch_then_commit, i_clk, i_rst_n, o_cmd.launch, ##1 o_cmd.commit)
    `MQSB_ASSERT_ALWAYS(a_cmd_exclusive, i_clk, i_rst_n, !(o_cmd.launch && o_cmd.commit))
    `MQSB_ASSERT_IMPL(a_commit_single, i_clk, i_rst_n, o_cmd.commit, ##1 !o_cmd.commit)

endmodule

### rtl/mqsb_dp.sv
`include "assert_macros.svh"

module mqsb_dp #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  mqsb_pkg::t_cmd    i_cmd,
    input  mqsb_pkg::t_item   i_item,
    output mqsb_pkg::t_result o_result,
    output logic              o_done
);

    // a 2-bit queue id reaches at most four queues
    localparam int QN = (QUEUES < 4) ? QUEUES : 4;
    localparam int QW = (QN > 1) ? $clog2(QN) : 1;
    localparam int AW = $clog2(SLOTS);
    localparam int LW = $clog2(SLOTS + 1);
    localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

    // slot store
    logic [LW-1:0]     mem_link [SLOTS];
    logic signed [31:0] mem_data [SLOTS];

    // list pointers
    logic [LW-1:0] r_head [QN];
    logic [LW-1:0] r_tail [QN];
    logic [LW-1:0] r_fh;
    // slots below the watermark have had their link written
    logic [LW-1:0] r_w;

    // item held between launch and commit
    logic               r_act;
    logic [QW-1:0]      r_qidx;
    logic               r_ok;
    logic               r_head_null;
    logic [LW-1:0]      r_slot;
    logic signed [31:0] r_data_in;
    logic [LW-1:0]      r_link_q;
    logic signed [31:0] r_data_q;

    mqsb_pkg::t_result r_result;
    logic              r_done;

    logic          w_qv;
    logic [QW-1:0] w_qidx;
    logic [LW-1:0] w_head_sel;
    logic [LW-1:0] w_tail_sel;
    logic          w_head_null;
    logic          w_ok;
    logic [LW-1:0] w_slot;
    logic [LW-1:0] w_link_res;
    logic          w_lwe;
    logic [AW-1:0] w_lwaddr;
    logic [LW-1:0] w_lwdata;

    // decode the incoming beat against the current pointers
    always_comb begin
        w_qv        = (32'(i_item.queue_id) < 32'(QUEUES));
        w_qidx      = i_item.queue_id[QW-1:0];
        w_head_sel  = w_qv ? r_head[w_qidx] : NULL_LINK;
        w_tail_sel  = w_qv ? r_tail[w_qidx] : NULL_LINK;
        w_head_null = !(w_head_sel < NULL_LINK);
        if (i_item.action == mqsb_pkg::ACT_ENQ) begin
            w_ok   = w_qv && (r_fh < NULL_LINK);
            w_slot = r_fh;
        end else begin
            w_ok   = !w_head_null;
            w_slot = w_head_sel;
        end
    end

    // link of the slot read at launch, never-written slots link to the next one
    assign w_link_res = (r_slot < r_w) ? r_link_q : (r_slot + LW'(1));

    // single link write port shared by launch and commit
    always_comb begin
        w_lwe    = 1'b0;
        w_lwaddr = r_slot[AW-1:0];
        w_lwdata = NULL_LINK;
        if (i_cmd.launch) begin
            w_lwaddr = w_tail_sel[AW-1:0];
            w_lwdata = r_fh;
            w_lwe    = (i_item.action == mqsb_pkg::ACT_ENQ) && w_ok && !w_head_null;
        end else if (i_cmd.commit && r_ok) begin
            w_lwe    = 1'b1;
            w_lwaddr = r_slot[AW-1:0];
            w_lwdata = (r_act == mqsb_pkg::ACT_ENQ) ? NULL_LINK : r_fh;
        end
    end

    // slot store ports
    always_ff @(posedge i_clk) begin
        if (w_lwe) mem_link[w_lwaddr] <= w_lwdata;
        if (i_cmd.commit && r_ok && (r_act == mqsb_pkg::ACT_ENQ)) begin
            mem_data[r_slot[AW-1:0]] <= r_data_in;
        end
        if (i_cmd.launch) begin
            r_link_q <= mem_link[w_slot[AW-1:0]];
            r_data_q <= mem_data[w_slot[AW-1:0]];
        end
    end

    // capture the beat at launch
    always_ff @(posedge i_clk) begin
        if (i_cmd.launch) begin
            r_act       <= i_item.action;
            r_qidx      <= w_qidx;
            r_ok        <= w_ok;
            r_head_null <= w_head_null;
            r_slot      <= w_slot;
            r_data_in   <= i_item.data_in;
        end
    end

    // pointer update at commit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < QN; i++) begin
                r_head[i] <= NULL_LINK;
                r_tail[i] <= NULL_LINK;
            end
            r_fh <= '0;
            r_w  <= '0;
        end else if (i_cmd.commit && r_ok) begin
            if (r_act == mqsb_pkg::ACT_ENQ) begin
                r_fh           <= w_link_res;
                r_tail[r_qidx] <= r_slot;
                if (r_head_null) r_head[r_qidx] <= r_slot;
                if (r_slot == r_w) r_w <= r_w + LW'(1);
            end else begin
                r_head[r_qidx] <= w_link_res;
                r_fh           <= r_slot;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            if (r_act == mqsb_pkg::ACT_ENQ) begin
                r_result.data_out <= '0;
                r_result.status   <= r_ok ? mqsb_pkg::ST_OK : mqsb_pkg::ST_FULL;
            end else if (r_ok) begin
                r_result.data_out <= r_data_q;
                r_result.status   <= mqsb_pkg::ST_OK;
            end else begin
                r_result.data_out <= mqsb_pkg::EMPTY_WORD;
                r_result.status   <= mqsb_pkg::ST_EMPTY;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= i_cmd.commit;
        end
    end

    assign o_result = r_result;
    assign o_done   = r_done;

    `MQSB_ASSERT_IMPL(a_done_after_commit, i_clk, i_rst_n, i_cmd.commit, ##1 o_done)
    `MQSB_ASSERT_ALWAYS(a_fh_range, i_clk, i_rst_n, r_fh <= NULL_LINK)
    `MQSB_ASSERT_ALWAYS(a_mark_range, i_clk, i_rst_n, r_w <= NULL_LINK)

endmodule

### rtl/multi_queue_shared_buffer.sv
// Up to four FIFO queues sharing one store of SLOTS words through linked lists
// and a free list. An item is taken when start is high and busy is low. The
// launch cycle reads the link and data store (one registered read port, one
// write port), the commit cycle writes back links and pointers, and the result
// beat appears on o_result with o_done high for exactly one cycle after commit.
// busy is high only during the commit cycle, so a new item can start in the
// same cycle that a result is shown. Results cannot be held off: sample
// o_result whenever o_done is high. Status 0 is ok, 1 is a refused enqueue (no
// free slot, or a queue id at or above QUEUES), 2 a refused dequeue (queue
// empty or queue id at or above QUEUES, data_out -1). After reset the store
// is usable at once, with no clearing pass.
module multi_queue_shared_buffer #(
    parameter int SLOTS  = 16,
    parameter int QUEUES = 4
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  mqsb_pkg::t_item   i_item,
    output mqsb_pkg::t_result o_result,
    output logic              o_done
);

    mqsb_pkg::t_cmd w_cmd;

    // sequencer
    mqsb_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_cmd   (w_cmd)
    );

    // list pointers and slot store
    mqsb_dp #(
        .SLOTS  (SLOTS),
        .QUEUES (QUEUES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (w_cmd),
        .i_item   (i_item),
        .o_result (o_result),
        .o_done   (o_done)
    );

endmodule

### sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NSLOTS  = 16;
    localparam int NQUEUES = 4;
    localparam int PTR_W   = $clog2(NSLOTS + 1);
    localparam int SLOT_W  = $clog2(NSLOTS);
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NSLOTS);

    localparam mqsb_pkg::t_result R_EMPTY  = '{data_out: mqsb_pkg::EMPTY_WORD,
                                               status: mqsb_pkg::ST_EMPTY};
    localparam mqsb_pkg::t_result R_ENQ_OK = '{data_out: 32'sd0, status: mqsb_pkg::ST_OK};
    localparam mqsb_pkg::t_result R_FULL   = '{data_out: 32'sd0, status: mqsb_pkg::ST_FULL};

    // one line of the directed stimulus
    typedef struct {
        logic               action;
        logic [1:0]         queue_id;
        logic signed [31:0] word;
        int                 reps;
        bit                 pinned;
        mqsb_pkg::t_result  want;
    } t_stim_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    mqsb_pkg::t_item   i_item  = '0;
    mqsb_pkg::t_result o_result;
    logic              o_done;

    // typed expectation travelling with the item
    bit                pin_valid  = 1'b0;
    mqsb_pkg::t_result pin_result = '0;

    // shadow copy of the queue store
    logic [PTR_W-1:0]   sh_head [NQUEUES];
    logic [PTR_W-1:0]   sh_tail [NQUEUES];
    logic [PTR_W-1:0]   sh_link [NSLOTS];
    logic signed [31:0] sh_word [NSLOTS];
    logic [PTR_W-1:0]   sh_free;

    mqsb_pkg::t_result pending_results[$];
    t_stim_row         stim_rows[$];
    int                mismatches = 0;
    bit                quiet_run  = 1'b0;

    multi_queue_shared_buffer #(
        .SLOTS (NSLOTS),
        .QUEUES(NQUEUES)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_item  (i_item),
        .o_result(o_result),
        .o_done  (o_done)
    );

    // 100 MHz clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit is_slot(input logic [PTR_W-1:0] p);
        return int'(p) < NSLOTS;
    endfunction

    // apply one enqueue or dequeue to the shadow store, return its result beat
    function automatic mqsb_pkg::t_result queue_op_outcome(input mqsb_pkg::t_item it);
        mqsb_pkg::t_result r;
        logic [PTR_W-1:0]  idx;
        int                q;
        r.data_out = 32'sd0;
        r.status   = mqsb_pkg::ST_OK;
        q = int'(it.queue_id);
        if (it.action == mqsb_pkg::ACT_ENQ) begin
            if (q >= NQUEUES || !is_slot(sh_free)) begin
                r.status = mqsb_pkg::ST_FULL;
            end else begin
                idx     = sh_free;
                sh_free = sh_link[idx[SLOT_W-1:0]];
                if (!is_slot(sh_head[q])) begin
                    sh_head[q] = idx;
                end else if (is_slot(sh_tail[q])) begin
                    sh_link[sh_tail[q][SLOT_W-1:0]] = idx;
                end
                sh_link[idx[SLOT_W-1:0]] = NULL_PTR;
                sh_tail[q]               = idx;
                sh_word[idx[SLOT_W-1:0]] = it.data_in;
            end
        end else begin
            if (q >= NQUEUES || !is_slot(sh_head[q])) begin
                r.status   = mqsb_pkg::ST_EMPTY;
                r.data_out = mqsb_pkg::EMPTY_WORD;
            end else begin
                idx                      = sh_head[q];
                sh_head[q]               = sh_link[idx[SLOT_W-1:0]];
                sh_link[idx[SLOT_W-1:0]] = sh_free;
                sh_free                  = idx;
                r.data_out               = sh_word[idx[SLOT_W-1:0]];
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        mismatches++;
        $display("mismatch at %0t ns: %s", $realtime, msg);
    endtask

    function automatic void add_row(input logic act, input logic [1:0] q,
                                    input logic signed [31:0] w, input int reps,
                                    input bit pinned, input mqsb_pkg::t_result want);
        t_stim_row row;
        row.action   = act;
        row.queue_id = q;
        row.word     = w;
        row.reps     = reps;
        row.pinned   = pinned;
        row.want     = want;
        stim_rows.push_back(row);
    endfunction

    // present one beat after a random gap and hold it until taken
    task automatic send_beat(input mqsb_pkg::t_item it, input bit pinned,
                             input mqsb_pkg::t_result want);
        int gap;
        gap = quiet_run ? 0 : $urandom_range(0, 10);
        if (gap != 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_item     <= it;
        pin_valid  <= pinned;
        pin_result <= want;
        do @(posedge i_clk); while (busy);
    endtask

    // hold off the sender until every result is back
    task automatic drain_results();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    // check results first, then predict the beat taken at this edge
    always @(posedge i_clk) begin
        mqsb_pkg::t_result want;
        mqsb_pkg::t_result got;
        if (i_rst_n) begin
            if (o_done) begin
                if (pending_results.size() == 0) begin
                    report_mismatch($sformatf("result %0d/%0d with nothing pending",
                                              o_result.data_out, o_result.status));
                end else begin
                    want = pending_results.pop_front();
                    if (o_result.data_out !== want.data_out) begin
                        report_mismatch($sformatf("data_out %h, expected %h",
                                                  o_result.data_out, want.data_out));
                    end
                    if (o_result.status !== want.status) begin
                        report_mismatch($sformatf("status %0d, expected %0d",
                                                  o_result.status, want.status));
                    end
                end
            end
            if (start && !busy) begin
                got = queue_op_outcome(i_item);
                pending_results.push_back(pin_valid ? pin_result : got);
            end
        end
    end

    // run limit
    initial begin
        #3_000_000;
        $display("tb NOT OK");
        $finish;
    end

    initial begin
        mqsb_pkg::t_item it;
        int              enq_pct;
        int              hot_q;

        // shadow state after reset
        for (int i = 0; i < NQUEUES; i++) begin
            sh_head[i] = NULL_PTR;
            sh_tail[i] = NULL_PTR;
        end
        for (int i = 0; i < NSLOTS; i++) begin
            sh_link[i] = (i + 1 < NSLOTS) ? PTR_W'(i + 1) : NULL_PTR;
            sh_word[i] = 32'sd0;
        end
        sh_free = '0;

        // directed rows: empty queues, word extremes, fill to full, drain to empty
        add_row(mqsb_pkg::ACT_DEQ, 2'd0, 32'sd0,           1, 1'b1, R_EMPTY);
        add_row(mqsb_pkg::ACT_DEQ, 2'd3, -32'sd1,          1, 1'b1, R_EMPTY);
        add_row(mqsb_pkg::ACT_ENQ, 2'd0, 32'sh7FFF_FFFF,   1, 1'b1, R_ENQ_OK);
        add_row(mqsb_pkg::ACT_ENQ, 2'd0, 32'sh8000_0000,   1, 1'b1, R_ENQ_OK);
        add_row(mqsb_pkg::ACT_ENQ, 2'd1, -32'sd1,          1, 1'b1, R_ENQ_OK);
        add_row(mqsb_pkg::ACT_ENQ, 2'd3, 32'sd0,           1, 1'b1, R_ENQ_OK);
        add_row(mqsb_pkg::ACT_DEQ, 2'd0, 32'sd0,           1, 1'b1,
                '{data_out: 32'sh7FFF_FFFF, status: mqsb_pkg::ST_OK});
        add_row(mqsb_pkg::ACT_DEQ, 2'd0, 32'sd0,           1, 1'b1,
                '{data_out: 32'sh8000_0000, status: mqsb_pkg::ST_OK});
        // queue just emptied by a dequeue
        add_row(mqsb_pkg::ACT_DEQ, 2'd0, 32'sd0,           1, 1'b1, R_EMPTY);
        add_row(mqsb_pkg::ACT_ENQ, 2'd0, 32'sh5A5A_5A5A,   1, 1'b0, '0);
        // stored -1 comes back with ok status
        add_row(mqsb_pkg::ACT_DEQ, 2'd1, 32'sd0,           1, 1'b1,
                '{data_out: -32'sd1, status: mqsb_pkg::ST_OK});
        // use up every free slot
        add_row(mqsb_pkg::ACT_ENQ, 2'd2, 32'shA5A5_0000,  14, 1'b0, '0);
        add_row(mqsb_pkg::ACT_ENQ, 2'd1, 32'sh1111_1111,   1, 1'b1, R_FULL);
        add_row(mqsb_pkg::ACT_ENQ, 2'd2, 32'sh2222_2222,   1, 1'b1, R_FULL);
        add_row(mqsb_pkg::ACT_DEQ, 2'd2, 32'sd0,           1, 1'b0, '0);
        add_row(mqsb_pkg::ACT_ENQ, 2'd1, 32'sh1234_5678,   1, 1'b0, '0);
        add_row(mqsb_pkg::ACT_ENQ, 2'd0, 32'sh3333_3333,   1, 1'b1, R_FULL);
        add_row(mqsb_pkg::ACT_DEQ, 2'd3, 32'sd0,           1, 1'b0, '0);
        add_row(mqsb_pkg::ACT_DEQ, 2'd2, 32'sd0,          13, 1'b0, '0);
        add_row(mqsb_pkg::ACT_DEQ, 2'd2, 32'sd0,           1, 1'b1, R_EMPTY);
        add_row(mqsb_pkg::ACT_DEQ, 2'd1, 32'sd0,           1, 1'b0, '0);
        add_row(mqsb_pkg::ACT_DEQ, 2'd0, 32'sd0,           1, 1'b0, '0);
        add_row(mqsb_pkg::ACT_DEQ, 2'd1, 32'sd0,           1, 1'b1, R_EMPTY);
        add_row(mqsb_pkg::ACT_DEQ, 2'd3, 32'sd0,           1, 1'b1, R_EMPTY);

        // hold synchronous reset, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        foreach (stim_rows[r]) begin
            for (int k = 0; k < stim_rows[r].reps; k++) begin
                it.action   = stim_rows[r].action;
                it.queue_id = stim_rows[r].queue_id;
                it.data_in  = stim_rows[r].word + k;
                send_beat(it, stim_rows[r].pinned, stim_rows[r].want);
            end
        end
        drain_results();

        // random part: phases with their own enqueue mix, hot queue and pacing
        for (int ph = 0; ph < 11; ph++) begin
            enq_pct   = $urandom_range(25, 80);
            hot_q     = $urandom_range(0, NQUEUES - 1);
            quiet_run = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 96; n++) begin
                it.action   = ($urandom_range(0, 99) < enq_pct) ? mqsb_pkg::ACT_ENQ
                                                                : mqsb_pkg::ACT_DEQ;
                it.queue_id = ($urandom_range(0, 1) == 0) ? 2'(hot_q)
                                                          : 2'($urandom_range(0, 3));
                case ($urandom_range(0, 9))
                    0:       it.data_in = 32'sh7FFF_FFFF;
                    1:       it.data_in = 32'sh8000_0000;
                    2:       it.data_in = -32'sd1;
                    3:       it.data_in = 32'sd0;
                    default: it.data_in = $urandom;
                endcase
                send_beat(it, 1'b0, '0);
            end
            if (ph == 3 || ph == 7) begin
                drain_results();
            end
        end

        // wait out the last results
        drain_results();
        repeat (8) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", pending_results.size()));
        end
        if (mismatches == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
